/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wes_pkg.sv */
// Shared types and constants of the weighted event selector.
package wes_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 32;
    localparam int TOTAL_W    = 42;
    localparam int COUNT_W    = 11;
    localparam int WIDE_W     = 48;
    localparam int IDX_WIDE_W = 17;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

/* rtl/wes_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module wes_ram #(
    parameter int WIDTH = wes_pkg::WEIGHT_BITS_DEF,
    parameter int DEPTH = wes_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/wes_target.sv */
// Two-stage unit that forms the sample target (total * fraction) >> 32.
module wes_target (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        launch,
    input  logic [wes_pkg::TOTAL_W-1:0] total,
    input  logic [wes_pkg::FRAC_W-1:0]  fraction,
    output logic [wes_pkg::TOTAL_W-1:0] target
);

    localparam int HI_W   = wes_pkg::TOTAL_W - wes_pkg::FRAC_W;
    localparam int PROD_W = 2 * wes_pkg::FRAC_W;
    localparam int SUM_W  = wes_pkg::TOTAL_W + 1;

    logic [PROD_W-1:0]           prod_lo_reg;
    logic [HI_W-1:0]             hi_reg;
    logic [wes_pkg::FRAC_W-1:0]  frac_reg;
    logic                        stage_vld_reg;
    logic [wes_pkg::TOTAL_W-1:0] target_reg;
    logic [SUM_W-1:0]            sum_next;

    assign sum_next = SUM_W'(hi_reg) * SUM_W'(frac_reg)
                    + SUM_W'(prod_lo_reg[PROD_W-1:wes_pkg::FRAC_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= launch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            prod_lo_reg <= PROD_W'(total[wes_pkg::FRAC_W-1:0]) * PROD_W'(fraction);
            hi_reg      <= total[wes_pkg::TOTAL_W-1:wes_pkg::FRAC_W];
            frac_reg    <= fraction;
        end
        if (stage_vld_reg)
        begin
            target_reg <= sum_next[wes_pkg::TOTAL_W-1:0];
        end
    end

    assign target = target_reg;

endmodule

/* rtl/weighted_event_selector.sv */
// Top level of the weighted event selector: weight table, totals and sample scan.
//
// A request is taken when start is high and busy is low; its result appears on the
// result ports with done high for exactly one cycle, and the receiver cannot hold it
// off. A write or read of an entry inside the table passes through ST_WRITE or
// ST_READ, which use the registered memory read, and a request that touches no entry
// answers from idle. A sample passes through ST_MUL and then ST_SCAN, which reads the
// weight memory one entry per cycle through its single read port. After reset a
// clearing pass writes zero to every entry, one per cycle, and keeps busy high until
// the pass ends. The reported total and count are those after the request.
module weighted_event_selector #(
    parameter int TABLE_DEPTH = wes_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = wes_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [wes_pkg::INDEX_W-1:0] entry_index,
    input  logic [wes_pkg::VALUE_W-1:0] weight_value,
    input  logic [wes_pkg::FRAC_W-1:0]  random_fraction,
    output logic                        done,
    output logic                        event_valid,
    output logic [wes_pkg::INDEX_W-1:0] event_index,
    output logic [wes_pkg::VALUE_W-1:0] entry_value,
    output logic [wes_pkg::TOTAL_W-1:0] weight_total,
    output logic [wes_pkg::COUNT_W-1:0] active_count
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PART_W = WEIGHT_BITS + ADDR_W;
    localparam int CMP_W  = (PART_W > wes_pkg::TOTAL_W) ? PART_W : wes_pkg::TOTAL_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_SCAN
    } state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;
    logic [wes_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [WEIGHT_BITS-1:0]      val_reg, val_next;
    logic [ADDR_W-1:0]           scan_addr_reg, scan_addr_next;
    logic [ADDR_W-1:0]           data_idx_reg, data_idx_next;
    logic [PART_W-1:0]           partial_reg, partial_next;
    logic [wes_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [wes_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [wes_pkg::INDEX_W-1:0] mark_reg, mark_next;
    logic                        done_reg, done_next;
    logic                        ev_valid_reg, ev_valid_next;
    logic [wes_pkg::INDEX_W-1:0] ev_index_reg, ev_index_next;
    logic [wes_pkg::VALUE_W-1:0] entry_reg, entry_next;

    logic                            accept;
    logic [wes_pkg::IDX_WIDE_W-1:0]  in_idx_wide;
    logic                            in_range;
    logic [wes_pkg::WIDE_W-1:0]      in_val_wide;
    logic [wes_pkg::WIDE_W-1:0]      old_wide;
    logic [wes_pkg::WIDE_W-1:0]      new_wide;
    logic [wes_pkg::IDX_WIDE_W-1:0]  data_idx_wide;
    logic [PART_W-1:0]               scan_sum;
    logic                            scan_hit;
    logic                            launch;
    logic [wes_pkg::TOTAL_W-1:0]     target;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [WEIGHT_BITS-1:0] ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [WEIGHT_BITS-1:0] ram_rd_data;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign in_idx_wide   = wes_pkg::IDX_WIDE_W'(entry_index);
    assign in_range      = in_idx_wide < wes_pkg::IDX_WIDE_W'(TABLE_DEPTH);
    assign in_val_wide   = wes_pkg::WIDE_W'(weight_value);
    assign old_wide      = wes_pkg::WIDE_W'(ram_rd_data);
    assign new_wide      = wes_pkg::WIDE_W'(val_reg);
    assign data_idx_wide = wes_pkg::IDX_WIDE_W'(data_idx_reg);
    assign scan_sum      = partial_reg + PART_W'(ram_rd_data);
    assign scan_hit      = CMP_W'(scan_sum) > CMP_W'(target);
    assign launch        = accept && (wes_pkg::op_t'(operation) == wes_pkg::OP_SAMPLE)
                           && (count_reg != '0);

    wes_target u_target (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (launch),
        .total    (total_reg),
        .fraction (random_fraction),
        .target   (target)
    );

    wes_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_addr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = in_idx_wide[ADDR_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                ram_rd_en = accept;
            end
            ST_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = addr_reg;
                ram_wr_data = val_reg;
            end
            ST_MUL:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
            end
            ST_SCAN:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = scan_addr_reg;
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        scan_addr_next = scan_addr_reg;
        data_idx_next  = data_idx_reg;
        partial_next   = partial_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        done_next      = 1'b0;
        ev_valid_next  = ev_valid_reg;
        ev_index_next  = ev_index_reg;
        entry_next     = entry_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next     = in_idx_wide[ADDR_W-1:0];
                    idx_next      = entry_index;
                    val_next      = in_val_wide[WEIGHT_BITS-1:0];
                    ev_valid_next = 1'b0;
                    ev_index_next = '0;
                    entry_next    = '0;
                    case (wes_pkg::op_t'(operation))
                        wes_pkg::OP_WRITE:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        wes_pkg::OP_SAMPLE:
                        begin
                            if (count_reg == '0)
                            begin
                                total_next = '0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_MUL;
                            end
                        end
                        wes_pkg::OP_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                count_next = count_reg
                           - wes_pkg::COUNT_W'(ram_rd_data != '0)
                           + wes_pkg::COUNT_W'(val_reg != '0);
                total_next = total_reg
                           - old_wide[wes_pkg::TOTAL_W-1:0]
                           + new_wide[wes_pkg::TOTAL_W-1:0];
                if ((val_reg != '0) && (idx_reg > mark_reg))
                begin
                    mark_next = idx_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                entry_next = old_wide[wes_pkg::VALUE_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                scan_addr_next = ADDR_W'(1);
                data_idx_next  = '0;
                partial_next   = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_hit || (data_idx_reg == LAST_ADDR))
                begin
                    ev_valid_next = 1'b1;
                    ev_index_next = scan_hit ? data_idx_wide[wes_pkg::INDEX_W-1:0]
                                             : mark_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    partial_next  = scan_sum;
                    data_idx_next = scan_addr_reg;
                    if (scan_addr_reg != LAST_ADDR)
                    begin
                        scan_addr_next = scan_addr_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            addr_reg      <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            scan_addr_reg <= '0;
            data_idx_reg  <= '0;
            partial_reg   <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            mark_reg      <= '0;
            done_reg      <= 1'b0;
            ev_valid_reg  <= 1'b0;
            ev_index_reg  <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            addr_reg      <= addr_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            scan_addr_reg <= scan_addr_next;
            data_idx_reg  <= data_idx_next;
            partial_reg   <= partial_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            done_reg      <= done_next;
            ev_valid_reg  <= ev_valid_next;
            ev_index_reg  <= ev_index_next;
            entry_reg     <= entry_next;
        end
    end

    assign done         = done_reg;
    assign event_valid  = ev_valid_reg;
    assign event_index  = ev_index_reg;
    assign entry_value  = entry_reg;
    assign weight_total = total_reg;
    assign active_count = count_reg;

endmodule

/* rtl/wes_checker.sv */
// Port-level assertions for the weighted event selector and their bind.
`include "assert_macros.svh"

module wes_checker #(
    parameter int TABLE_DEPTH = wes_pkg::TABLE_DEPTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  operation,
    input logic                        done,
    input logic                        event_valid,
    input logic [wes_pkg::INDEX_W-1:0] event_index,
    input logic [wes_pkg::VALUE_W-1:0] entry_value,
    input logic [wes_pkg::TOTAL_W-1:0] weight_total,
    input logic [wes_pkg::COUNT_W-1:0] active_count
);

    // The count cannot wrap when the table has fewer entries than its range.
    localparam logic COUNT_EXACT = (TABLE_DEPTH < (1 << wes_pkg::COUNT_W));

    `WES_ASSERT_NXT(a_unused_op, clk, rst_n, start && !busy && (operation == wes_pkg::OP_NONE), done && !event_valid && (entry_value == '0), "Unused operation did not answer at once with an empty result.")
    `WES_ASSERT_IMP(a_no_event_index, clk, rst_n, done && !event_valid, event_index == '0, "Result without an event carries a nonzero event index.")
    `WES_ASSERT_IMP(a_event_no_entry, clk, rst_n, done && event_valid, (entry_value == '0) && (!COUNT_EXACT || (active_count != '0)), "Sample result carries an entry value or reports no active entries.")
    `WES_ASSERT_IMP(a_empty_total, clk, rst_n, done && COUNT_EXACT && (active_count == '0), weight_total == '0, "Table with no active entries reports a nonzero total.")

endmodule

bind weighted_event_selector wes_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_wes_checker (.*);
